>>> hw/rtl/bal_pkg.sv
// ============================================================================
// bal_pkg - bounded array list shared types
// Opcodes, status codes, controller states and the command/status bundles
// that join the controller to the datapath.
// ============================================================================
package bal_pkg;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 3'd0,
        OP_DUMP   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_REMOVE = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SH_RD,
        S_SH_WR,
        S_DUMP_RD,
        S_DUMP_EMIT,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} t_cnt_op;
    typedef enum logic [1:0] {IDX_HOLD, IDX_POS, IDX_ZERO, IDX_INC} t_idx_op;
    typedef enum logic [1:0] {WR_AT_COUNT, WR_AT_POS, WR_AT_IDX}    t_wr_sel;
    typedef enum logic       {RD_IDX, RD_IDX_NEXT}                  t_rd_sel;
    typedef enum logic       {OUT_SINGLE, OUT_ENTRY}                t_out_kind;

    typedef struct packed {
        logic      in_ready;
        logic      status_ld;
        t_status   status;
        logic      wr_en;
        t_wr_sel   wr_sel;
        t_rd_sel   rd_sel;
        t_cnt_op   cnt_op;
        t_idx_op   idx_op;
        logic      out_ld;
        t_out_kind out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic               in_valid;
        t_opcode            op;
        logic               full;
        logic               pos_ok;
        logic               empty;
        logic               idx_more;
        logic               idx_last;
        logic               out_free;
        logic [COUNT_W-1:0] count;
    } t_dp_stat;

endpackage

>>> hw/rtl/bal_if.sv
// ============================================================================
// bal_if - command and response channels
// Valid/ready channels; an item moves on a clock edge with both high.
// ============================================================================
interface bal_cmd_if;
    import bal_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [POS_W-1:0]           position;
    logic signed [VALUE_W-1:0]  value_in;

    modport source (output valid, output opcode, output position, output value_in,
                    input ready);
    modport sink   (input valid, input opcode, input position, input value_in,
                    output ready);
endinterface

interface bal_rsp_if;
    import bal_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  value_out;
    logic [POS_W-1:0]           entry_index;
    logic [COUNT_W-1:0]         count_now;
    logic                       last;

    modport source (output valid, output status, output value_out, output entry_index,
                    output count_now, output last, input ready);
    modport sink   (input valid, input status, input value_out, input entry_index,
                    input count_now, input last, output ready);
endinterface

>>> hw/rtl/bounded_array_list_engine.sv
// ============================================================================
// bounded_array_list_engine - bounded ordered list of signed words
// Top level: sequencer plus datapath around a DEPTH-entry store.
// ============================================================================
// An ordered list of up to DEPTH signed 32-bit values kept in a one-write,
// one-read RAM with a count. Each command item is taken only while the
// sequencer is idle; a finished response may still sit in the output
// register meanwhile. Append, write at index and clear are taken, executed,
// and then load their response. Remove at index p moves every later entry
// down through the single RAM read port, each with a read and then a write
// back, plus one final read check before the count drops. For a list of n
// entries a dump gives n response items, last set on the final one; an
// empty dump gives one item with the empty status. Opcodes 5 to 7 are
// dropped without a response. Entries at or above the count are never
// read, so the store needs no clearing after reset.
// ============================================================================
module bounded_array_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bal_cmd_if.sink   i_cmd,
    bal_rsp_if.source o_rsp
);
    import bal_pkg::*;

    t_dp_cmd  ctl_cmd;
    t_dp_stat dp_stat;

    // sequencer: decode and step the operation
    bal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (dp_stat),
        .o_cmd   (ctl_cmd)
    );

    // datapath: item registers, count, walk index, store, response register
    bal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_rsp   (o_rsp),
        .i_ctl   (ctl_cmd),
        .o_stat  (dp_stat)
    );

`ifndef SYNTHESIS
    // the count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_stat.count <= COUNT_W'(DEPTH))
        else $error("entry count above depth");

    // a response is loaded only when the output register can take it
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl_cmd.out_ld |-> dp_stat.out_free)
        else $error("response register overwritten");

    // no store write while a new item is taken
    a_no_wr_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |-> !ctl_cmd.wr_en)
        else $error("store write during item take");

    // a clear empties the list through its execute state
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && i_cmd.opcode == OP_CLEAR)
            |=> ##1 (dp_stat.count == '0))
        else $error("clear left entries");
`endif
endmodule

>>> hw/rtl/bal_ram.sv
// ============================================================================
// bal_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
module bal_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/bal_ctrl.sv
// ============================================================================
// bal_ctrl - list operation sequencer
// Decodes the held item and steps the datapath through updates, shifts
// and dumps.
// ============================================================================
module bal_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bal_pkg::t_dp_stat i_stat,
    output bal_pkg::t_dp_cmd  o_cmd
);
    import bal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_stat.op)
                    OP_APPEND, OP_WRITE, OP_CLEAR: n_state = S_RESP;
                    OP_DUMP:   n_state = i_stat.empty  ? S_RESP  : S_DUMP_RD;
                    OP_REMOVE: n_state = i_stat.pos_ok ? S_SH_RD : S_RESP;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_SH_RD: begin
                n_state = i_stat.idx_more ? S_SH_WR : S_RESP;
            end
            S_SH_WR: begin
                n_state = S_SH_RD;
            end
            S_DUMP_RD: begin
                n_state = S_DUMP_EMIT;
            end
            S_DUMP_EMIT: begin
                if (i_stat.out_free) n_state = i_stat.idx_last ? S_IDLE : S_DUMP_RD;
            end
            S_RESP: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.in_ready  = 1'b0;
        o_cmd.status_ld = 1'b0;
        o_cmd.status    = ST_OK;
        o_cmd.wr_en     = 1'b0;
        o_cmd.wr_sel    = WR_AT_COUNT;
        o_cmd.rd_sel    = RD_IDX;
        o_cmd.cnt_op    = CNT_HOLD;
        o_cmd.idx_op    = IDX_HOLD;
        o_cmd.out_ld    = 1'b0;
        o_cmd.out_kind  = OUT_SINGLE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            S_EXEC: begin
                o_cmd.status_ld = 1'b1;
                unique case (i_stat.op)
                    OP_APPEND: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_AT_COUNT;
                            o_cmd.cnt_op = CNT_INC;
                        end
                    end
                    OP_WRITE: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = WR_AT_POS;
                        end else begin
                            o_cmd.status = ST_RANGE;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.cnt_op = CNT_CLR;
                    end
                    OP_DUMP: begin
                        if (i_stat.empty) o_cmd.status = ST_EMPTY;
                        o_cmd.idx_op = IDX_ZERO;
                    end
                    OP_REMOVE: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.idx_op = IDX_POS;
                        end else begin
                            o_cmd.status = ST_RANGE;
                        end
                    end
                    default: o_cmd.status_ld = 1'b0;
                endcase
            end
            S_SH_RD: begin
                if (i_stat.idx_more) begin
                    o_cmd.rd_sel = RD_IDX_NEXT;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                end
            end
            S_SH_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = WR_AT_IDX;
                o_cmd.idx_op = IDX_INC;
            end
            S_DUMP_RD: begin
                o_cmd.rd_sel = RD_IDX;
            end
            S_DUMP_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = OUT_ENTRY;
                    if (!i_stat.idx_last) o_cmd.idx_op = IDX_INC;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_kind = OUT_SINGLE;
                end
            end
            default: o_cmd.in_ready = 1'b0;
        endcase
    end
endmodule

>>> hw/rtl/bal_dp.sv
// ============================================================================
// bal_dp - list datapath
// Item holding registers, entry count, walk index, entry store and the
// response register.
// ============================================================================
module bal_dp #(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bal_cmd_if.sink           i_cmd,
    bal_rsp_if.source         o_rsp,
    input  bal_pkg::t_dp_cmd  i_ctl,
    output bal_pkg::t_dp_stat o_stat
);
    import bal_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_opcode              r_op;
    logic [POS_W-1:0]     r_pos;
    logic [VALUE_W-1:0]   r_val;
    t_status              r_status;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        n_idx;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [VALUE_W-1:0]   r_out_value;
    logic [POS_W-1:0]     r_out_index;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_last;

    logic [COUNT_W-1:0]   count_ext;
    logic [COUNT_W-1:0]   idx_next_ext;
    logic [AW-1:0]        idx_next;
    logic                 in_take;
    logic                 out_free;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;

    assign count_ext    = COUNT_W'(r_count);
    assign idx_next_ext = COUNT_W'(r_idx) + COUNT_W'(1);
    assign idx_next     = r_idx + AW'(1);
    assign in_take      = i_cmd.valid && i_ctl.in_ready;
    assign out_free     = !r_out_valid || o_rsp.ready;

    assign i_cmd.ready  = i_ctl.in_ready;

    // hold the item
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= t_opcode'(i_cmd.opcode);
            r_pos <= i_cmd.position;
            r_val <= i_cmd.value_in;
        end
        if (i_ctl.status_ld) r_status <= i_ctl.status;
    end

    always_comb begin
        unique case (i_ctl.cnt_op)
            CNT_INC:  n_count = r_count + CW'(1);
            CNT_DEC:  n_count = r_count - CW'(1);
            CNT_CLR:  n_count = '0;
            default:  n_count = r_count;
        endcase
        unique case (i_ctl.idx_op)
            IDX_POS:  n_idx = r_pos[AW-1:0];
            IDX_ZERO: n_idx = '0;
            IDX_INC:  n_idx = idx_next;
            default:  n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_idx <= n_idx;
    end

    // entry store
    always_comb begin
        ram_we = i_ctl.wr_en;
        unique case (i_ctl.wr_sel)
            WR_AT_POS: ram_waddr = r_pos[AW-1:0];
            WR_AT_IDX: ram_waddr = r_idx;
            default:   ram_waddr = r_count[AW-1:0];
        endcase
        ram_wdata = (i_ctl.wr_sel == WR_AT_IDX) ? ram_rdata : r_val;
        ram_raddr = (i_ctl.rd_sel == RD_IDX_NEXT) ? idx_next : r_idx;
    end

    bal_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_ctl.out_ld) begin
            r_out_count <= count_ext;
            if (i_ctl.out_kind == OUT_ENTRY) begin
                r_out_status <= ST_OK;
                r_out_value  <= ram_rdata;
                r_out_index  <= POS_W'(r_idx);
                r_out_last   <= (idx_next_ext == count_ext);
            end else begin
                r_out_status <= r_status;
                r_out_value  <= '0;
                r_out_index  <= '0;
                r_out_last   <= 1'b1;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.value_out   = $signed(r_out_value);
    assign o_rsp.entry_index = r_out_index;
    assign o_rsp.count_now   = r_out_count;
    assign o_rsp.last        = r_out_last;

    assign o_stat.in_valid = i_cmd.valid;
    assign o_stat.op       = r_op;
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.pos_ok   = ({1'b0, r_pos} < count_ext);
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.idx_more = (idx_next_ext < count_ext);
    assign o_stat.idx_last = (idx_next_ext == count_ext);
    assign o_stat.out_free = out_free;
    assign o_stat.count    = count_ext;
endmodule

>>> tb/bounded_array_list_engine_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// bounded_array_list_engine_tb - self-checking bench for the array list engine
// Drives list commands (append, write, remove, clear, dump and spare codes)
// through the command channel. A behavioral copy of the list predicts every
// response item, and the checker compares each one field by field in order.
// Both channels idle and stall at random, with one stretch at full rate.
// ============================================================================
module bounded_array_list_engine_tb;
    import bal_pkg::*;

    localparam int LIST_DEPTH  = 64;
    localparam int IDLE_PCT    = 21;      // percent of cycles a side holds off
    localparam int SETTLE_CYC  = 160;     // longer than a full 64-entry dump
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_OPS  = 130;

    // Opcodes 5 to 7 carry no operation; the block drops them silently.
    localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

    // One response item as the block should present it.
    typedef struct {
        t_status                   status;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          index;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_list_reply;

    logic i_clk;
    logic i_rst_n;

    bal_cmd_if cmd_bus ();
    bal_rsp_if rsp_bus ();

    bounded_array_list_engine #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the list; only entries below list_len are meaningful.
    logic signed [VALUE_W-1:0] list_mem [LIST_DEPTH];
    int                        list_len;
    t_list_reply               pending_replies [$];
    int                        fault_count;
    bit                        calm;          // suppress idling on both sides

    // ------------------------------------------------------------------------
    // Clock: 4 ns period.
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void queue_reply(t_status st, logic signed [VALUE_W-1:0] val,
                                        int idx, int cnt, logic is_last);
        t_list_reply r;
        r.status = st;
        r.value  = val;
        r.index  = POS_W'(idx);
        r.count  = COUNT_W'(cnt);
        r.last   = is_last;
        pending_replies.push_back(r);
    endfunction

    // Apply one accepted command to the shadow list and queue its responses.
    function automatic void apply_list_op(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                          logic signed [VALUE_W-1:0] val);
        t_status st;
        st = ST_OK;
        case (op)
            OP_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            end
            OP_DUMP: begin
                // An empty dump still answers once, flagged empty.
                if (list_len == 0) begin
                    queue_reply(ST_EMPTY, '0, 0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < list_len; i++)
                        queue_reply(ST_OK, list_mem[i], i, list_len, i == list_len - 1);
                end
                return;
            end
            OP_WRITE: begin
                if (int'(pos) >= list_len)
                    st = ST_RANGE;
                else
                    list_mem[pos] = val;
            end
            OP_CLEAR: begin
                // Keep the stored words; they just fall outside the list.
                list_len = 0;
            end
            OP_REMOVE: begin
                if (int'(pos) >= list_len) begin
                    st = ST_RANGE;
                end else begin
                    for (int i = int'(pos); i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            default: return;   // spare opcode: dropped, no response
        endcase
        queue_reply(st, '0, 0, list_len, 1'b1);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Drive one command item at the falling edge and hold it until taken.
    // Valid stays high on return; the next call or release_cmd updates it at
    // the following falling edge, so it is never re-taken.
    task automatic send_item(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                             logic signed [VALUE_W-1:0] val);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            cmd_bus.valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        cmd_bus.valid    = 1'b1;
        cmd_bus.opcode   = op;
        cmd_bus.position = pos;
        cmd_bus.value_in = val;
        do @(posedge i_clk); while (cmd_bus.ready !== 1'b1);
        apply_list_op(op, pos, val);
    endtask

    // Drop valid and hold off until every predicted response has arrived.
    task automatic release_cmd();
        @(negedge i_clk);
        cmd_bus.valid = 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] any_word();
        return $urandom;
    endfunction

    // Mostly a valid index, sometimes anything the field can hold.
    function automatic logic [POS_W-1:0] pick_position();
        if (list_len > 0 && $urandom_range(99) < 80)
            return POS_W'($urandom_range(list_len - 1, 0));
        return POS_W'($urandom_range(LIST_DEPTH - 1, 0));
    endfunction

    function automatic logic [OPCODE_W-1:0] OP_OP_SPARE();
        return OPCODE_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Dump, write, remove and clear on an empty list, plus the spare opcodes.
    task automatic test_empty_list();
        send_item(OP_DUMP,   '0, '0);
        send_item(OP_WRITE,  6'd0, WORD_MAX);
        send_item(OP_REMOVE, 6'd0, '0);
        send_item(OP_REMOVE, 6'd63, '0);
        send_item(OP_CLEAR,  '0, '0);
        send_item(OP_SPARE_FIRST, 6'd21, 32'sh1234_5678);
        send_item(OP_SPARE_LAST,  6'd42, WORD_MIN);
        release_cmd();
    endtask

    // Extreme values, range errors at the boundary, and removes at both ends.
    task automatic test_edge_values();
        send_item(OP_APPEND, '0, WORD_MAX);
        send_item(OP_APPEND, 6'd63, WORD_MIN);
        send_item(OP_APPEND, '0, '0);
        send_item(OP_APPEND, '0, -32'sd1);
        send_item(OP_APPEND, '0, 32'sh5555_AAAA);
        send_item(OP_WRITE,  6'd2, 32'shAAAA_5555);
        send_item(OP_WRITE,  6'd5, WORD_MAX);        // index equal to count
        send_item(OP_WRITE,  6'd63, WORD_MIN);
        send_item(OP_DUMP,   '0, '0);
        send_item(OP_REMOVE, 6'd4, '0);              // tail entry
        send_item(OP_REMOVE, 6'd0, '0);              // head entry, shifts all
        send_item(OP_REMOVE, 6'd1, '0);
        send_item(OP_DUMP,   '0, '0);
        send_item(OP_CLEAR,  '0, '0);
        send_item(OP_DUMP,   '0, '0);
        send_item(OP_APPEND, '0, 32'sh0F0F_F0F0);
        send_item(OP_DUMP,   '0, '0);
        release_cmd();
    endtask

    // Fill the store, overflow it, and shift the longest possible tail.
    task automatic test_full_store();
        send_item(OP_CLEAR, '0, '0);
        for (int i = 0; i < LIST_DEPTH; i++)
            send_item(OP_APPEND, POS_W'($urandom), any_word());
        send_item(OP_APPEND, '0, WORD_MAX);          // refused: store full
        send_item(OP_WRITE,  6'd63, WORD_MIN);
        send_item(OP_DUMP,   '0, '0);
        send_item(OP_REMOVE, 6'd0, '0);
        send_item(OP_APPEND, '0, any_word());
        send_item(OP_REMOVE, 6'd63, '0);
        send_item(OP_REMOVE, 6'd63, '0);             // now past the end
        send_item(OP_DUMP,   '0, '0);
        send_item(OP_CLEAR,  '0, '0);
        release_cmd();
    endtask

    // Weighted random operations; a middle stretch runs with no idling.
    task automatic test_random_ops(int n_ops);
        int pick;
        for (int k = 0; k < n_ops; k++) begin
            calm = (k >= 50 && k < 90);
            pick = $urandom_range(99);
            // Turn appends into writes or removes once the list grows long, to keep dumps short.
            if (list_len > 32 && pick < 35)
                pick = pick + 40;
            if (pick < 35)
                send_item(OP_APPEND, POS_W'($urandom), any_word());
            else if (pick < 55)
                send_item(OP_WRITE, pick_position(), any_word());
            else if (pick < 77)
                send_item(OP_REMOVE, pick_position(), any_word());
            else if (pick < 89)
                send_item(OP_DUMP, POS_W'($urandom), any_word());
            else if (pick < 95)
                send_item(OP_CLEAR, POS_W'($urandom), any_word());
            else
                send_item(OP_OP_SPARE(), POS_W'($urandom), any_word());
        end
        calm = 1'b0;
        release_cmd();
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stalls, checked against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        rsp_bus.ready = calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic void note_fault(string msg);
        if (fault_count < MAX_REPORTS)
            $display("[%0t] %s", $time, msg);
        fault_count++;
    endfunction

    always @(posedge i_clk) begin
        t_list_reply want;
        if (i_rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_replies.size() == 0) begin
                note_fault($sformatf("unexpected response st=%0d val=%0d idx=%0d cnt=%0d last=%0b",
                                     rsp_bus.status, rsp_bus.value_out, rsp_bus.entry_index,
                                     rsp_bus.count_now, rsp_bus.last));
            end else begin
                want = pending_replies.pop_front();
                if (rsp_bus.status !== want.status || rsp_bus.value_out !== want.value ||
                    rsp_bus.entry_index !== want.index || rsp_bus.count_now !== want.count ||
                    rsp_bus.last !== want.last) begin
                    note_fault($sformatf({"response mismatch: expected st=%0d val=%0d idx=%0d ",
                                          "cnt=%0d last=%0b, got st=%0d val=%0d idx=%0d ",
                                          "cnt=%0d last=%0b"},
                                         want.status, want.value, want.index, want.count,
                                         want.last, rsp_bus.status, rsp_bus.value_out,
                                         rsp_bus.entry_index, rsp_bus.count_now,
                                         rsp_bus.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        calm             = 1'b0;
        list_len         = 0;
        fault_count      = 0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.opcode   = '0;
        cmd_bus.position = '0;
        cmd_bus.value_in = '0;
        foreach (list_mem[i]) list_mem[i] = '0;

        // Hold reset, then release it on a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_edge_values();
        test_full_store();
        test_random_ops(RANDOM_OPS);

        // Let any dropped spare item finish before closing out.
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (pending_replies.size() != 0)
            note_fault($sformatf("%0d predicted responses never arrived",
                                 pending_replies.size()));

        if (fault_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
